// File: hdl/cfa_pkg.sv
`default_nettype none

package cfa_pkg;

   localparam int POS_WIDTH_DEF = 32;
   localparam int SUM_WIDTH_DEF = 64;
   localparam int SCALE_WIDTH   = 32;
   localparam int CHARGE_WIDTH  = 16;
   localparam int QPROD_WIDTH   = 2 * CHARGE_WIDTH;
   localparam int QMAG_WIDTH    = QPROD_WIDTH - 1;
   localparam int FRAC_SHIFT    = 24;
   localparam int FORCE_WIDTH   = 64;

   localparam logic [SCALE_WIDTH-1:0] SCALE_RESET = 32'd65536;

   localparam logic [1:0] AXIS_X = 2'd0;
   localparam logic [1:0] AXIS_Y = 2'd1;
   localparam logic [1:0] AXIS_Z = 2'd2;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_SQX,
      OP_SQY,
      OP_SQZ,
      OP_SQRT,
      OP_R2,
      OP_R3,
      OP_KQ,
      OP_NUM,
      OP_DIV,
      OP_ACC,
      OP_SHOW
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [1:0] axis;
   } cmd_type;

   typedef struct packed {
      logic busy;
      logic zero;
      logic last;
   } status_type;

endpackage

`default_nettype wire

// File: hdl/cfa_datapath.sv
`default_nettype none

module cfa_datapath
   import cfa_pkg::*;
#(
   parameter int POS_WIDTH = POS_WIDTH_DEF,
   parameter int SUM_WIDTH = SUM_WIDTH_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire cmd_type                       cmd,
   output status_type                         status,
   input  wire logic                          csr_write,
   input  wire logic [SCALE_WIDTH-1:0]        csr_data,
   input  wire logic signed [POS_WIDTH-1:0]   req_target_x,
   input  wire logic signed [POS_WIDTH-1:0]   req_target_y,
   input  wire logic signed [POS_WIDTH-1:0]   req_target_z,
   input  wire logic signed [CHARGE_WIDTH-1:0] req_target_charge,
   input  wire logic signed [POS_WIDTH-1:0]   req_other_x,
   input  wire logic signed [POS_WIDTH-1:0]   req_other_y,
   input  wire logic signed [POS_WIDTH-1:0]   req_other_z,
   input  wire logic signed [CHARGE_WIDTH-1:0] req_other_charge,
   input  wire logic                          req_first_pair,
   input  wire logic                          req_last_pair,
   output logic signed [FORCE_WIDTH-1:0]      rsp_force_x,
   output logic signed [FORCE_WIDTH-1:0]      rsp_force_y,
   output logic signed [FORCE_WIDTH-1:0]      rsp_force_z,
   output logic                               rsp_coincident_seen,
   output logic                               rsp_overflow_seen
);

   localparam int DW   = POS_WIDTH + 1;
   localparam int SW   = 2 * DW;
   localparam int RW   = DW;
   localparam int R3W  = 3 * DW;
   localparam int KQW  = SCALE_WIDTH + QMAG_WIDTH;
   localparam int MAW  = (2 * DW > KQW) ? 2 * DW : KQW;
   localparam int MBW  = (DW > QMAG_WIDTH) ? DW : QMAG_WIDTH;
   localparam int PW   = MAW + MBW;
   localparam int NPW  = DW + KQW;
   localparam int NW   = NPW + FRAC_SHIFT;
   localparam int DRW  = R3W + 1;
   localparam int CW   = $clog2(NW);

   localparam logic [SUM_WIDTH-1:0] SUM_MAX = {1'b0, {(SUM_WIDTH-1){1'b1}}};
   localparam logic [SUM_WIDTH-1:0] SUM_MIN = {1'b1, {(SUM_WIDTH-1){1'b0}}};

   logic signed [DW-1:0]          dx_ff, dy_ff, dz_ff;
   logic signed [DW-1:0]          dx_in, dy_in, dz_in;
   logic                          qneg_ff;
   logic [QMAG_WIDTH-1:0]         qmag_ff;
   logic signed [QPROD_WIDTH-1:0] qprod_in;
   logic [QPROD_WIDTH-1:0]        qabs_in;
   logic                          last_ff;
   logic [SCALE_WIDTH-1:0]        scale_ff;
   logic [SW-1:0]                 ssq_ff;
   logic [RW-1:0]                 root_ff;
   logic [RW+1:0]                 srem_ff;
   logic [R3W-1:0]                r3_ff;
   logic [KQW-1:0]                kq_ff;
   logic [PW-1:0]                 mul_a_ff, mul_p_ff, mul_p_in, mul_a_start, mul_b_ext;
   logic [MBW-1:0]                mul_b_ff, mul_b_start;
   logic [NW-1:0]                 num_ff, quo_ff;
   logic [DRW-1:0]                drem_ff, div_sh_in, div_den;
   logic                          div_ge;
   logic [RW+3:0]                 sq_sh_in, sq_trial;
   logic                          sq_ge;
   logic                          busy_ff;
   logic [CW-1:0]                 cnt_ff;
   op_type                        op_ff;
   logic signed [SUM_WIDTH-1:0]   sx_ff, sy_ff, sz_ff;
   logic                          zflag_ff, sflag_ff;
   logic signed [DW-1:0]          d_sel;
   logic [DW-1:0]                 dmag_sel;
   logic signed [SUM_WIDTH-1:0]   s_sel, term_in, sum_in;
   logic [SUM_WIDTH-1:0]          qm;
   logic                          neg, big, term_sat, add_ovf;
   logic [SUM_WIDTH:0]            wide_in;
   logic                          mul_start;

   function automatic logic [DW-1:0] mag_of(input logic signed [DW-1:0] v);
      mag_of = v[DW-1] ? DW'(~v + 1'b1) : DW'(v);
   endfunction

   assign dx_in    = DW'(req_target_x) - DW'(req_other_x);
   assign dy_in    = DW'(req_target_y) - DW'(req_other_y);
   assign dz_in    = DW'(req_target_z) - DW'(req_other_z);
   assign qprod_in = QPROD_WIDTH'(req_target_charge) * QPROD_WIDTH'(req_other_charge);
   assign qabs_in  = qprod_in[QPROD_WIDTH-1] ? QPROD_WIDTH'(~qprod_in + 1'b1)
                                              : QPROD_WIDTH'(qprod_in);

   always_comb begin
      unique case (cmd.axis)
         AXIS_X: begin
            d_sel = dx_ff;
            s_sel = sx_ff;
         end
         AXIS_Y: begin
            d_sel = dy_ff;
            s_sel = sy_ff;
         end
         default: begin
            d_sel = dz_ff;
            s_sel = sz_ff;
         end
      endcase
      dmag_sel = mag_of(d_sel);
   end

   always_comb begin
      mul_start   = 1'b1;
      mul_a_start = '0;
      mul_b_start = '0;
      unique case (cmd.op)
         OP_SQX: begin
            mul_a_start = PW'(mag_of(dx_ff));
            mul_b_start = MBW'(mag_of(dx_ff));
         end
         OP_SQY: begin
            mul_a_start = PW'(mag_of(dy_ff));
            mul_b_start = MBW'(mag_of(dy_ff));
         end
         OP_SQZ: begin
            mul_a_start = PW'(mag_of(dz_ff));
            mul_b_start = MBW'(mag_of(dz_ff));
         end
         OP_R2: begin
            mul_a_start = PW'(root_ff);
            mul_b_start = MBW'(root_ff);
         end
         OP_R3: begin
            mul_a_start = PW'(r3_ff[2*RW-1:0]);
            mul_b_start = MBW'(root_ff);
         end
         OP_KQ: begin
            mul_a_start = PW'(scale_ff);
            mul_b_start = MBW'(qmag_ff);
         end
         OP_NUM: begin
            mul_a_start = PW'(kq_ff);
            mul_b_start = MBW'(dmag_sel);
         end
         default: mul_start = 1'b0;
      endcase
   end

   always_comb begin
      mul_b_ext = mul_b_ff[0] ? mul_a_ff : '0;
      mul_p_in  = mul_p_ff + mul_b_ext;

      sq_sh_in = {srem_ff, ssq_ff[SW-1 -: 2]};
      sq_trial = (RW+4)'({root_ff, 2'b01});
      sq_ge    = sq_sh_in >= sq_trial;

      div_sh_in = {drem_ff[DRW-2:0], num_ff[NW-1]};
      div_den   = DRW'(r3_ff);
      div_ge    = div_sh_in >= div_den;

      neg      = d_sel[DW-1] ^ qneg_ff;
      big      = |quo_ff[NW-1:SUM_WIDTH];
      qm       = quo_ff[SUM_WIDTH-1:0];
      term_sat = big || (neg ? (qm > SUM_MIN) : (qm >= SUM_MIN));
      if (term_sat) begin
         term_in = neg ? SUM_MIN : SUM_MAX;
      end else begin
         term_in = neg ? SUM_WIDTH'(~qm + 1'b1) : qm;
      end
      wide_in = {s_sel[SUM_WIDTH-1], s_sel} + {term_in[SUM_WIDTH-1], term_in};
      add_ovf = wide_in[SUM_WIDTH] != wide_in[SUM_WIDTH-1];
      if (add_ovf) begin
         sum_in = term_in[SUM_WIDTH-1] ? SUM_MIN : SUM_MAX;
      end else begin
         sum_in = wide_in[SUM_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         cnt_ff   <= '0;
         op_ff    <= OP_NONE;
         scale_ff <= SCALE_RESET;
         sx_ff    <= '0;
         sy_ff    <= '0;
         sz_ff    <= '0;
         zflag_ff <= 1'b0;
         sflag_ff <= 1'b0;
         last_ff  <= 1'b0;
      end else begin
         if (csr_write) begin
            scale_ff <= csr_data;
         end

         if (cmd.op == OP_LOAD) begin
            dx_ff   <= dx_in;
            dy_ff   <= dy_in;
            dz_ff   <= dz_in;
            qneg_ff <= qprod_in[QPROD_WIDTH-1];
            qmag_ff <= qabs_in[QMAG_WIDTH-1:0];
            last_ff <= req_last_pair;
            if (req_first_pair) begin
               sx_ff    <= '0;
               sy_ff    <= '0;
               sz_ff    <= '0;
               sflag_ff <= 1'b0;
            end
            zflag_ff <= (zflag_ff & ~req_first_pair) |
                        (dx_in == '0 && dy_in == '0 && dz_in == '0);
         end

         if (mul_start) begin
            busy_ff  <= 1'b1;
            op_ff    <= cmd.op;
            cnt_ff   <= CW'(MBW - 1);
            mul_a_ff <= mul_a_start;
            mul_b_ff <= mul_b_start;
            mul_p_ff <= '0;
         end else if (cmd.op == OP_SQRT) begin
            busy_ff <= 1'b1;
            op_ff   <= OP_SQRT;
            cnt_ff  <= CW'(RW - 1);
            srem_ff <= '0;
            root_ff <= '0;
         end else if (cmd.op == OP_DIV) begin
            busy_ff <= 1'b1;
            op_ff   <= OP_DIV;
            cnt_ff  <= CW'(NW - 1);
            drem_ff <= '0;
            quo_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
            end
            unique case (op_ff)
               OP_SQRT: begin
                  srem_ff <= sq_ge ? (RW+2)'(sq_sh_in - sq_trial) : (RW+2)'(sq_sh_in);
                  root_ff <= {root_ff[RW-2:0], sq_ge};
                  ssq_ff  <= {ssq_ff[SW-3:0], 2'b00};
               end
               OP_DIV: begin
                  drem_ff <= div_ge ? (div_sh_in - div_den) : div_sh_in;
                  quo_ff  <= {quo_ff[NW-2:0], div_ge};
                  num_ff  <= {num_ff[NW-2:0], 1'b0};
               end
               default: begin
                  mul_p_ff <= mul_p_in;
                  mul_a_ff <= {mul_a_ff[PW-2:0], 1'b0};
                  mul_b_ff <= {1'b0, mul_b_ff[MBW-1:1]};
                  if (cnt_ff == '0) begin
                     priority case (op_ff)
                        OP_SQX:        ssq_ff <= mul_p_in[SW-1:0];
                        OP_SQY, OP_SQZ: ssq_ff <= ssq_ff + mul_p_in[SW-1:0];
                        OP_R2, OP_R3:  r3_ff  <= mul_p_in[R3W-1:0];
                        OP_KQ:         kq_ff  <= mul_p_in[KQW-1:0];
                        default:       num_ff <= {mul_p_in[NPW-1:0], {FRAC_SHIFT{1'b0}}};
                     endcase
                  end
               end
            endcase
         end

         if (cmd.op == OP_ACC) begin
            if (term_sat || add_ovf) begin
               sflag_ff <= 1'b1;
            end
            unique case (cmd.axis)
               AXIS_X:  sx_ff <= sum_in;
               AXIS_Y:  sy_ff <= sum_in;
               default: sz_ff <= sum_in;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_SHOW) begin
         rsp_force_x         <= FORCE_WIDTH'(sx_ff);
         rsp_force_y         <= FORCE_WIDTH'(sy_ff);
         rsp_force_z         <= FORCE_WIDTH'(sz_ff);
         rsp_coincident_seen <= zflag_ff;
         rsp_overflow_seen   <= sflag_ff;
      end
   end

   assign status.busy = busy_ff;
   assign status.zero = dx_ff == '0 && dy_ff == '0 && dz_ff == '0;
   assign status.last = last_ff;

endmodule

`default_nettype wire

// File: hdl/cfa_controller.sv
`default_nettype none

module cfa_controller
   import cfa_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output cmd_type          cmd,
   input  wire status_type  status
);

   typedef enum logic [1:0] {ST_IDLE, ST_ISSUE, ST_WAIT, ST_FINISH} state_type;

   state_type  state_ff;
   op_type     step_ff;
   logic [1:0] axis_ff;
   logic       rsp_valid_ff;
   logic       slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = state_ff == ST_IDLE;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd.op   = OP_NONE;
      cmd.axis = axis_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.op = OP_LOAD;
            end
         end
         ST_ISSUE: begin
            if (!(step_ff == OP_SQX && status.zero)) begin
               cmd.op = step_ff;
            end
         end
         ST_FINISH: begin
            if (status.last && slot_free) begin
               cmd.op = OP_SHOW;
            end
         end
         default: cmd.op = OP_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= OP_SQX;
         axis_ff      <= AXIS_X;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.op == OP_SHOW) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  state_ff <= ST_ISSUE;
                  step_ff  <= OP_SQX;
                  axis_ff  <= AXIS_X;
               end
            end
            ST_ISSUE: begin
               if (step_ff == OP_SQX && status.zero) begin
                  state_ff <= ST_FINISH;
               end else if (step_ff == OP_ACC) begin
                  if (axis_ff == AXIS_Z) begin
                     state_ff <= ST_FINISH;
                  end else begin
                     axis_ff <= axis_ff + 1'b1;
                     step_ff <= OP_NUM;
                  end
               end else begin
                  state_ff <= ST_WAIT;
               end
            end
            ST_WAIT: begin
               if (!status.busy) begin
                  state_ff <= ST_ISSUE;
                  unique case (step_ff)
                     OP_SQX:  step_ff <= OP_SQY;
                     OP_SQY:  step_ff <= OP_SQZ;
                     OP_SQZ:  step_ff <= OP_SQRT;
                     OP_SQRT: step_ff <= OP_R2;
                     OP_R2:   step_ff <= OP_R3;
                     OP_R3:   step_ff <= OP_KQ;
                     OP_KQ:   step_ff <= OP_NUM;
                     OP_NUM:  step_ff <= OP_DIV;
                     default: step_ff <= OP_ACC;
                  endcase
               end
            end
            default: begin
               if (!status.last || slot_free) begin
                  state_ff <= ST_IDLE;
               end
            end
         endcase
      end
   end

   a_show_sets_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.op == OP_SHOW |=> rsp_valid_ff)
      else $error("result register not marked valid after load");

   a_show_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.op == OP_SHOW |-> slot_free)
      else $error("pending result overwritten");

   a_start_when_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_SQX || cmd.op == OP_SQRT || cmd.op == OP_DIV || cmd.op == OP_NUM)
      |-> !status.busy)
      else $error("datapath step issued while busy");

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      status.busy |-> !req_ready)
      else $error("transaction accepted during computation");

endmodule

`default_nettype wire

// File: hdl/coulomb_force_accumulator_core.sv
`default_nettype none

// Channel   Ports                          Direction   Transaction
// req       req_valid/req_ready, fields    in          one particle pair
// rsp       rsp_valid/rsp_ready, fields    out         force sum and flags after a last pair
// csr       csr_valid/csr_ready, csr_data  in          write of the Coulomb scale
//
// Each pair is worked through a bit-serial multiplier, a digit-serial square root and a
// restoring divider; the next pair is accepted only once the current one is through.
// A pair at zero distance skips the arithmetic and leaves the sums unchanged.
// Reset is synchronous; it clears the sums and the flags and sets the scale to 65536.
// A pending result does not stop the next pair from being accepted unless a new result is
// ready; such a result is held, and no pair is accepted, until the output register frees.

module coulomb_force_accumulator_core
   import cfa_pkg::*;
#(
   parameter int POS_WIDTH = POS_WIDTH_DEF,
   parameter int SUM_WIDTH = SUM_WIDTH_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [SCALE_WIDTH-1:0]         csr_data,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic signed [POS_WIDTH-1:0]    req_target_x,
   input  wire logic signed [POS_WIDTH-1:0]    req_target_y,
   input  wire logic signed [POS_WIDTH-1:0]    req_target_z,
   input  wire logic signed [CHARGE_WIDTH-1:0] req_target_charge,
   input  wire logic signed [POS_WIDTH-1:0]    req_other_x,
   input  wire logic signed [POS_WIDTH-1:0]    req_other_y,
   input  wire logic signed [POS_WIDTH-1:0]    req_other_z,
   input  wire logic signed [CHARGE_WIDTH-1:0] req_other_charge,
   input  wire logic                           req_first_pair,
   input  wire logic                           req_last_pair,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic signed [FORCE_WIDTH-1:0]       rsp_force_x,
   output logic signed [FORCE_WIDTH-1:0]       rsp_force_y,
   output logic signed [FORCE_WIDTH-1:0]       rsp_force_z,
   output logic                                rsp_coincident_seen,
   output logic                                rsp_overflow_seen
);

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   cfa_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   cfa_datapath #(
      .POS_WIDTH (POS_WIDTH),
      .SUM_WIDTH (SUM_WIDTH)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .csr_write           (csr_valid && csr_ready),
      .csr_data            (csr_data),
      .req_target_x        (req_target_x),
      .req_target_y        (req_target_y),
      .req_target_z        (req_target_z),
      .req_target_charge   (req_target_charge),
      .req_other_x         (req_other_x),
      .req_other_y         (req_other_y),
      .req_other_z         (req_other_z),
      .req_other_charge    (req_other_charge),
      .req_first_pair      (req_first_pair),
      .req_last_pair       (req_last_pair),
      .rsp_force_x         (rsp_force_x),
      .rsp_force_y         (rsp_force_y),
      .rsp_force_z         (rsp_force_z),
      .rsp_coincident_seen (rsp_coincident_seen),
      .rsp_overflow_seen   (rsp_overflow_seen)
   );

endmodule

`default_nettype wire
